@@ rtl/nrm_pkg.sv @@
// Shared types, constants and the symbol-to-impact mapping for the range-minimum block.
package nrm_pkg;

  // Store size as built; positions are POS_W bits wide, so at most 2**POS_W entries are reachable
  localparam int DEPTH       = 1024;
  localparam int POS_W       = 10;
  localparam int SYM_W       = 8;
  localparam int CODE_W      = 3;
  localparam int STORE_DEPTH = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Input tdata layout, lowest bit first: position, symbol, range_start, range_end
  localparam int POS_LSB    = 0;
  localparam int SYM_LSB    = POS_LSB + POS_W;
  localparam int START_LSB  = SYM_LSB + SYM_W;
  localparam int END_LSB    = START_LSB + POS_W;
  localparam int IN_BITS    = END_LSB + POS_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CODE_W + 7) / 8) * 8;

  // Item kinds carried on s_axis_tuser
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // ASCII characters with an impact code
  localparam logic [SYM_W-1:0] CHAR_A = 8'h41;
  localparam logic [SYM_W-1:0] CHAR_C = 8'h43;
  localparam logic [SYM_W-1:0] CHAR_G = 8'h47;
  localparam logic [SYM_W-1:0] CHAR_T = 8'h54;

  localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
  localparam logic [CODE_W-1:0] CODE_A    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_C    = 3'd2;
  localparam logic [CODE_W-1:0] CODE_G    = 3'd3;
  localparam logic [CODE_W-1:0] CODE_T    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  function automatic logic [CODE_W-1:0] impact_of(input logic [SYM_W-1:0] ch);
    logic [CODE_W-1:0] code;
    unique case (ch)
      CHAR_A:  code = CODE_A;
      CHAR_C:  code = CODE_C;
      CHAR_G:  code = CODE_G;
      CHAR_T:  code = CODE_T;
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/nucleotide_range_minimum.sv @@
// Nucleotide impact store with inclusive range-minimum queries.
// Load transfer: written to the store at the accept edge, next item accepted the following cycle.
// Query transfer: one store read per cycle over the clamped range, then the result register
//   is loaded; a reversed range, or a start past the store, skips the scan.
// One query at a time: no new item is accepted while the scan over the store runs or the result waits to load.
// rst (synchronous, active high) clears control and output valid; store contents are not cleared.
module nucleotide_range_minimum (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [9:0] position, [17:10] symbol, [27:18] range_start, [37:28] range_end, rest zero
  input  logic [nrm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] kind: 0 load, 1 query
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] min_impact, rest zero
  output logic [nrm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] range_error
  output logic                           m_axis_tuser
);
  import nrm_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(STORE_DEPTH - 1);

  // Impact store: one write port (loads), one registered read port (scan)
  logic [CODE_W-1:0] mem [STORE_DEPTH];
  logic [CODE_W-1:0] rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  state_t            state, state_next;
  logic [POS_W:0]    idx;       // next position to read; one extra bit so it can pass the top
  logic [POS_W-1:0]  end_pos;   // last position to read, clamped to the store
  logic [CODE_W-1:0] best;      // running minimum, final result once the scan drains
  logic              err;
  logic              pend;      // rd_data holds a scanned entry this cycle
  logic              out_load;
  logic [CODE_W-1:0] res_min;
  logic              res_err;

  // Input field unpacking
  logic              in_kind;
  logic [POS_W-1:0]  in_pos;
  logic [SYM_W-1:0]  in_sym;
  logic [POS_W-1:0]  in_start;
  logic [POS_W-1:0]  in_end;
  logic              accept;
  logic              q_accept;
  logic              rev;
  logic              start_in;
  logic              scan_issue;
  logic [POS_W-1:0]  end_clamp;

  assign in_kind  = s_axis_tuser;
  assign in_pos   = s_axis_tdata[POS_LSB +: POS_W];
  assign in_sym   = s_axis_tdata[SYM_LSB +: SYM_W];
  assign in_start = s_axis_tdata[START_LSB +: POS_W];
  assign in_end   = s_axis_tdata[END_LSB +: POS_W];

  // Only idle takes items, so loads never overlap a scan of the store
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_accept      = accept && (in_kind == KIND_QUERY);
  assign wr_en         = accept && (in_kind == KIND_LOAD) && (in_pos <= LAST_POS);

  assign rev        = in_end < in_start;
  assign start_in   = in_start <= LAST_POS;
  assign end_clamp  = (in_end > LAST_POS) ? LAST_POS : in_end;
  assign scan_issue = idx <= {1'b0, end_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = idx[ADDR_W-1:0];
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_accept) begin
          if (!rev && start_in) begin
            // first read goes out on the accept edge
            rd_en      = 1'b1;
            rd_addr    = in_start[ADDR_W-1:0];
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          rd_en = 1'b1;
        end else if (!pend) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the result register to free up
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Store ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_pos[ADDR_W-1:0]] <= impact_of(in_sym);
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= rd_en;
    end
  end

  // Scan datapath
  always_ff @(posedge clk) begin
    if (q_accept) begin
      idx     <= {1'b0, in_start} + 1'b1;
      end_pos <= end_clamp;
      best    <= (!rev && start_in) ? '1 : CODE_NONE;
      err     <= rev;
    end else if (state == ST_SCAN) begin
      if (pend && (rd_data < best)) begin
        best <= rd_data;
      end
      if (scan_issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_min <= best;
      res_err <= err;
    end
  end

  assign m_axis_tdata = OUT_DATA_W'(res_min);
  assign m_axis_tuser = res_err;

endmodule

@@ rtl/nrm_checker.sv @@
// Port-level checks for the range-minimum block and their bind to the top level.
module nrm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [nrm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [nrm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);
  import nrm_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // reversed range reports a zero minimum
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result with nonzero minimum");

  // minimum is a legal impact code with zero padding
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata <= OUT_DATA_W'(CODE_T))
    else $error("minimum out of code range");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind nucleotide_range_minimum nrm_checker u_nrm_checker (.*);

@@ bench/nucleotide_range_minimum_test.sv @@
// Testbench for nucleotide_range_minimum: directed and random loads and range queries,
// checked against a scoreboard that predicts each query result.
module nucleotide_range_minimum_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nrm_pkg::*;

  // One query answer as the block returns it
  typedef struct packed {
    logic [CODE_W-1:0] min_impact;
    logic              range_error;
  } range_answer_t;

  // Keeps its own copy of the impact store and queues the answer of every accepted query
  class impact_scoreboard;
    logic [CODE_W-1:0] impact_copy [STORE_DEPTH];
    range_answer_t     pending_answers [$];
    int                failures;

    function new();
      failures = 0;
      foreach (impact_copy[i]) impact_copy[i] = CODE_NONE;
    endfunction

    task report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      failures++;
    endtask

    // Called at the accept edge of every input transfer
    function void note_transfer(input logic kind, input logic [POS_W-1:0] pos,
                                input logic [SYM_W-1:0] sym,
                                input logic [POS_W-1:0] first, input logic [POS_W-1:0] last);
      range_answer_t     ans;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] lowest;
      if (kind == KIND_LOAD) begin
        case (sym)
          CHAR_A:  code = CODE_A;
          CHAR_C:  code = CODE_C;
          CHAR_G:  code = CODE_G;
          CHAR_T:  code = CODE_T;
          default: code = CODE_NONE;
        endcase
        if (pos < STORE_DEPTH) impact_copy[pos] = code;
        return;
      end
      ans.min_impact  = CODE_NONE;
      ans.range_error = 1'b0;
      if (last < first) begin
        ans.range_error = 1'b1;
      end else begin
        lowest = 3'd7;
        // positions past the store are skipped; an empty scan answers zero
        for (int i = first; i <= last && i < STORE_DEPTH; i++)
          if (impact_copy[i] < lowest) lowest = impact_copy[i];
        if (first < STORE_DEPTH) ans.min_impact = lowest;
      end
      pending_answers.push_back(ans);
    endfunction

    // Called at the accept edge of every output transfer
    task check_result(input logic [CODE_W-1:0] min_impact, input logic range_error);
      range_answer_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result, min_impact", min_impact, -1);
        return;
      end
      want = pending_answers.pop_front();
      if (min_impact !== want.min_impact)
        report_mismatch("min_impact", min_impact, want.min_impact);
      if (range_error !== want.range_error)
        report_mismatch("range_error", range_error, want.range_error);
    endtask
  endclass

  localparam int RANDOM_PER_PHASE = 145;
  localparam int NUM_PHASES       = 4;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = KIND_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  impact_scoreboard sb = new();

  // Idle odds in percent, changed per phase
  int sender_idle   = 0;
  int receiver_stall = 0;

  // Positions loaded since reset; queries never reach past these
  bit loaded [STORE_DEPTH];

  nucleotide_range_minimum u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= receiver_stall);

  // Result monitor
  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[CODE_W-1:0], m_axis_tuser);

  // Drives one input transfer; entered and left at a falling edge
  task automatic send_transfer(input logic kind, input logic [POS_W-1:0] pos,
                               input logic [SYM_W-1:0] sym,
                               input logic [POS_W-1:0] first, input logic [POS_W-1:0] last);
    logic [IN_DATA_W-1:0] word;
    while ($urandom_range(99) < sender_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    word = '0;
    word[POS_LSB   +: POS_W] = pos;
    word[SYM_LSB   +: SYM_W] = sym;
    word[START_LSB +: POS_W] = first;
    word[END_LSB   +: POS_W] = last;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= word;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_transfer(kind, pos, sym, first, last);
    @(negedge clk);
  endtask

  // Load with random filler in the range fields, which a load ignores
  task automatic load_symbol(input logic [POS_W-1:0] pos, input logic [SYM_W-1:0] sym);
    loaded[pos] = 1'b1;
    send_transfer(KIND_LOAD, pos, sym, POS_W'($urandom), POS_W'($urandom));
  endtask

  // Query with random filler in position and symbol, which a query ignores
  task automatic query_range(input logic [POS_W-1:0] first, input logic [POS_W-1:0] last);
    send_transfer(KIND_QUERY, POS_W'($urandom), SYM_W'($urandom), first, last);
  endtask

  // Hard stop in case the block hangs
  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [SYM_W-1:0] nucleotides [4];
    logic [POS_W-1:0] cursor;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] last;
    int               span;
    int               probe;
    nucleotides[0] = CHAR_A;
    nucleotides[1] = CHAR_C;
    nucleotides[2] = CHAR_G;
    nucleotides[3] = CHAR_T;
    cursor = '0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every code, unknown characters, both store ends, overwrites,
    // reversed ranges including the widest one
    load_symbol(10'd0, CHAR_A);
    load_symbol(10'd1, CHAR_C);
    load_symbol(10'd2, CHAR_G);
    load_symbol(10'd3, CHAR_T);
    load_symbol(10'd4, 8'hFF);
    load_symbol(10'd1023, CHAR_T);
    load_symbol(10'd1022, 8'h00);
    query_range(10'd0, 10'd0);
    query_range(10'd1, 10'd3);
    query_range(10'd3, 10'd3);
    query_range(10'd0, 10'd4);
    query_range(10'd1023, 10'd1023);
    query_range(10'd1022, 10'd1023);
    query_range(10'd1023, 10'd0);
    query_range(10'd1, 10'd0);
    load_symbol(10'd4, CHAR_G);
    query_range(10'd2, 10'd4);
    load_symbol(10'd0, CHAR_T);
    query_range(10'd0, 10'd1);
    load_symbol(10'd5, 8'h61);   // lowercase a is not a nucleotide here
    query_range(10'd3, 10'd5);

    // Random phases: no idling, sender gaps, receiver stalls, both
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin sender_idle = 0;  receiver_stall = 0;  end
        1: begin sender_idle = 60; receiver_stall = 0;  end
        2: begin sender_idle = 0;  receiver_stall = 60; end
        default: begin sender_idle = 29; receiver_stall = 29; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(1) == 0) begin
          // Loads mostly march along a cursor so that long written runs build up
          if ($urandom_range(99) < 60) begin
            if ($urandom_range(99) < 5) cursor = POS_W'($urandom);
            first = cursor;
            cursor = cursor + 1'b1;
          end else begin
            first = POS_W'($urandom);
          end
          if ($urandom_range(99) < 85)
            load_symbol(first, nucleotides[$urandom_range(3)]);
          else
            load_symbol(first, SYM_W'($urandom));
        end else if ($urandom_range(99) < 10) begin
          // Reversed range: the store is not read, so any pair with last < first
          first = POS_W'($urandom_range(STORE_DEPTH - 1, 1));
          last  = POS_W'($urandom_range(first - 1, 0));
          query_range(first, last);
        end else begin
          // Start on a loaded position and grow the range only over loaded ones
          probe = $urandom_range(STORE_DEPTH - 1);
          for (int k = 0; k < STORE_DEPTH && !loaded[probe]; k++)
            probe = (probe + 1) % STORE_DEPTH;
          first = POS_W'(probe);
          case ($urandom_range(39))
            0:       span = $urandom_range(STORE_DEPTH - 1);
            1, 2, 3: span = $urandom_range(127);
            default: span = $urandom_range(15);
          endcase
          last = first;
          while (span > 0 && last < STORE_DEPTH - 1 && loaded[last + 1]) begin
            last = last + 1'b1;
            span--;
          end
          query_range(first, last);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow one full scan for anything stray
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (STORE_DEPTH + 16) @(posedge clk);

    if (sb.failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
